// File: hw/rtl/rau_pkg.sv
// ---------------------------------------------------------------------------
// rau_pkg
// shared widths, codes, payload words and internal types for the rational
// arithmetic unit
// ---------------------------------------------------------------------------
package rau_pkg;

  localparam int W     = 32;
  localparam int CNT_W = $clog2(W);

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_RED = 3'd4;
  localparam logic [2:0] OP_EQ  = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_ZERO_GCD = 2'd2;

  typedef struct packed {
    logic [2:0]          opcode;
    logic signed [W-1:0] a_num;
    logic signed [W-1:0] a_den;
    logic signed [W-1:0] b_num;
    logic signed [W-1:0] b_den;
  } in_word_t;

  typedef struct packed {
    logic signed [W-1:0] res_num;
    logic signed [W-1:0] res_den;
    logic                is_equal;
    logic [1:0]          status;
  } out_word_t;

  typedef enum logic {
    MODE_MUL,
    MODE_DIV
  } unit_mode_t;

  typedef struct packed {
    logic       start;
    unit_mode_t mode;
    logic [W-1:0] x;
    logic [W-1:0] y;
  } unit_req_t;

  typedef struct packed {
    logic         done;
    logic [W-1:0] hi;
    logic [W-1:0] lo;
  } unit_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ISSUE,
    S_P1,
    S_P2,
    S_P3,
    S_SUM,
    S_GCD,
    S_QN,
    S_QD,
    S_FIN
  } state_t;

endpackage

// File: hw/rtl/rau_iter_unit.sv
// ---------------------------------------------------------------------------
// rau_iter_unit
// shared one-bit-per-cycle unsigned unit: shift-add multiply giving a
// double-width product in {hi, lo}, or restoring divide giving the quotient
// in lo and the remainder in hi; W steps, then a one-cycle done pulse
// ---------------------------------------------------------------------------
module rau_iter_unit
  import rau_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  unit_req_t req,
  output unit_rsp_t rsp
);

  logic             busy;
  logic             done;
  unit_mode_t       mode;
  logic [CNT_W-1:0] cnt;
  logic [W-1:0]     hi;
  logic [W-1:0]     lo;
  logic [W-1:0]     opd;

  logic [W+1:0] add_a;
  logic [W+1:0] add_b;
  logic         add_cin;
  logic [W+1:0] sum;
  logic         ge;
  logic [W-1:0] hi_next;
  logic [W-1:0] lo_next;

  always_comb begin
    if (mode == MODE_MUL) begin
      add_a   = {2'b00, hi};
      add_b   = {2'b00, (lo[0] ? opd : '0)};
      add_cin = 1'b0;
    end else begin
      add_a   = {1'b0, hi, lo[W-1]};
      add_b   = ~{2'b00, opd};
      add_cin = 1'b1;
    end
    sum = add_a + add_b + {{(W+1){1'b0}}, add_cin};
    ge  = ~sum[W+1];
    if (mode == MODE_MUL) begin
      hi_next = sum[W:1];
      lo_next = {sum[0], lo[W-1:1]};
    end else begin
      hi_next = ge ? sum[W-1:0] : {hi[W-2:0], lo[W-1]};
      lo_next = {lo[W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start && !busy) begin
      mode <= req.mode;
      hi   <= '0;
      if (req.mode == MODE_MUL) begin
        lo  <= req.y;
        opd <= req.x;
      end else begin
        lo  <= req.x;
        opd <= req.y;
      end
    end else if (busy) begin
      hi <= hi_next;
      lo <= lo_next;
    end
  end

  assign rsp.done = done;
  assign rsp.hi   = hi;
  assign rsp.lo   = lo;

endmodule

// File: hw/rtl/rational_arithmetic_unit.sv
// ---------------------------------------------------------------------------
// rational_arithmetic_unit
// add, subtract, multiply and divide of two fractions by cross-multiplying,
// reduce by euclid gcd, and field-wise compare, on one shared iterative unit
// ---------------------------------------------------------------------------
//  channel  handshake             word        contents
//  request  req_valid/req_ready   req         opcode, a_num, a_den, b_num, b_den
//  result   rsp_valid/rsp_ready   rsp         res_num, res_den, is_equal, status
//
//  every multiply or divide runs on the shared unit (W = 32)
//  add/sub use three products on the shared unit, multiply/divide two
//  reduce runs k euclid remainder divides, then two quotient divides; compare none
//  one word at a time: req_ready is high only when no word is in work
//  a finished word waits in the output register; the next word is taken meanwhile
//  reset is synchronous and clears the sequencer and the output valid
// ---------------------------------------------------------------------------
module rational_arithmetic_unit
  import rau_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  in_word_t  req,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output out_word_t rsp
);

  state_t state, state_next;

  logic [2:0]          op;
  logic signed [W-1:0] an, ad, bn, bd;
  logic                pneg, pneg_next;
  logic [2*W-1:0]      p1, p1_next;
  logic [2*W-1:0]      p2, p2_next;
  logic [2*W-1:0]      p3, p3_next;
  logic [W-1:0]        gn, gn_next;
  logic [W-1:0]        gm, gm_next;
  logic [W-1:0]        r_num, r_num_next;
  logic [W-1:0]        r_den, r_den_next;
  logic                r_eq, r_eq_next;
  logic [1:0]          r_st, r_st_next;
  logic                load_out;

  unit_req_t ureq;
  unit_rsp_t ursp;

  logic [2*W-1:0] prod;
  logic [2*W-1:0] sprod;
  logic [W-1:0]   quo;
  logic [2*W:0]   e1, e2, vn;
  logic           fits_n, fits_d;

  function automatic logic [W-1:0] mag(input logic [W-1:0] v);
    mag = v[W-1] ? (~v + 1'b1) : v;
  endfunction

  rau_iter_unit u_iter (
    .clk (clk),
    .rst (rst),
    .req (ureq),
    .rsp (ursp)
  );

  assign req_ready = (state == S_IDLE);
  assign prod      = {ursp.hi, ursp.lo};
  assign sprod     = pneg ? (~prod + 1'b1) : prod;
  assign quo       = ursp.lo;

  always_comb begin
    e1 = {p1[2*W-1], p1};
    e2 = {p2[2*W-1], p2};
    case (op)
      OP_ADD:  vn = e1 + e2;
      OP_SUB:  vn = e1 - e2;
      default: vn = e1;
    endcase
    fits_n = (&vn[2*W:W-1]) || !(|vn[2*W:W-1]);
    fits_d = (&p3[2*W-1:W-1]) || !(|p3[2*W-1:W-1]);
  end

  always_comb begin
    state_next = state;
    pneg_next  = pneg;
    p1_next    = p1;
    p2_next    = p2;
    p3_next    = p3;
    gn_next    = gn;
    gm_next    = gm;
    r_num_next = r_num;
    r_den_next = r_den;
    r_eq_next  = r_eq;
    r_st_next  = r_st;
    ureq.start = 1'b0;
    ureq.mode  = MODE_MUL;
    ureq.x     = '0;
    ureq.y     = '0;
    load_out   = 1'b0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = S_ISSUE;
        end
      end
      S_ISSUE: begin
        r_num_next = '0;
        r_den_next = '0;
        r_eq_next  = 1'b0;
        r_st_next  = ST_OK;
        case (op)
          OP_ADD, OP_SUB, OP_DIV: begin
            ureq.start = 1'b1;
            ureq.x     = mag(an);
            ureq.y     = mag(bd);
            pneg_next  = an[W-1] ^ bd[W-1];
            state_next = S_P1;
          end
          OP_MUL: begin
            ureq.start = 1'b1;
            ureq.x     = mag(an);
            ureq.y     = mag(bn);
            pneg_next  = an[W-1] ^ bn[W-1];
            state_next = S_P1;
          end
          OP_RED: begin
            if (an != '0) begin
              ureq.start = 1'b1;
              ureq.mode  = MODE_DIV;
              ureq.x     = mag(ad);
              ureq.y     = mag(an);
              gn_next    = mag(an);
              state_next = S_GCD;
            end else if (ad == '0) begin
              r_num_next = an;
              r_den_next = ad;
              r_st_next  = ST_ZERO_GCD;
              state_next = S_FIN;
            end else begin
              ureq.start = 1'b1;
              ureq.mode  = MODE_DIV;
              ureq.x     = '0;
              ureq.y     = mag(ad);
              gm_next    = mag(ad);
              state_next = S_QN;
            end
          end
          OP_EQ: begin
            r_eq_next  = (an == bn) && (ad == bd);
            state_next = S_FIN;
          end
          default: begin
            state_next = S_FIN;
          end
        endcase
      end
      S_P1: begin
        if (ursp.done) begin
          p1_next    = sprod;
          ureq.start = 1'b1;
          if (op == OP_ADD || op == OP_SUB) begin
            ureq.x     = mag(bn);
            ureq.y     = mag(ad);
            pneg_next  = bn[W-1] ^ ad[W-1];
            state_next = S_P2;
          end else if (op == OP_DIV) begin
            ureq.x     = mag(ad);
            ureq.y     = mag(bn);
            pneg_next  = ad[W-1] ^ bn[W-1];
            state_next = S_P3;
          end else begin
            ureq.x     = mag(ad);
            ureq.y     = mag(bd);
            pneg_next  = ad[W-1] ^ bd[W-1];
            state_next = S_P3;
          end
        end
      end
      S_P2: begin
        if (ursp.done) begin
          p2_next    = sprod;
          ureq.start = 1'b1;
          ureq.x     = mag(ad);
          ureq.y     = mag(bd);
          pneg_next  = ad[W-1] ^ bd[W-1];
          state_next = S_P3;
        end
      end
      S_P3: begin
        if (ursp.done) begin
          p3_next    = sprod;
          state_next = S_SUM;
        end
      end
      S_SUM: begin
        r_num_next = vn[W-1:0];
        r_den_next = p3[W-1:0];
        r_st_next  = (fits_n && fits_d) ? ST_OK : ST_OVERFLOW;
        state_next = S_FIN;
      end
      S_GCD: begin
        if (ursp.done) begin
          ureq.start = 1'b1;
          ureq.mode  = MODE_DIV;
          if (ursp.hi != '0) begin
            ureq.x  = gn;
            ureq.y  = ursp.hi;
            gn_next = ursp.hi;
          end else begin
            ureq.x     = mag(an);
            ureq.y     = gn;
            gm_next    = gn;
            state_next = S_QN;
          end
        end
      end
      S_QN: begin
        if (ursp.done) begin
          r_num_next = an[W-1] ? (~quo + 1'b1) : quo;
          ureq.start = 1'b1;
          ureq.mode  = MODE_DIV;
          ureq.x     = mag(ad);
          ureq.y     = gm;
          state_next = S_QD;
        end
      end
      S_QD: begin
        if (ursp.done) begin
          r_den_next = ad[W-1] ? (~quo + 1'b1) : quo;
          r_st_next  = ST_OK;
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (!rsp_valid || rsp_ready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      op <= req.opcode;
      an <= req.a_num;
      ad <= req.a_den;
      bn <= req.b_num;
      bd <= req.b_den;
    end
    pneg  <= pneg_next;
    p1    <= p1_next;
    p2    <= p2_next;
    p3    <= p3_next;
    gn    <= gn_next;
    gm    <= gm_next;
    r_num <= r_num_next;
    r_den <= r_den_next;
    r_eq  <= r_eq_next;
    r_st  <= r_st_next;
    if (load_out) begin
      rsp.res_num  <= r_num;
      rsp.res_den  <= r_den;
      rsp.is_equal <= r_eq;
      rsp.status   <= r_st;
    end
  end

endmodule

// File: verif/tb_rational_arithmetic_unit.sv
// ---------------------------------------------------------------------------
// tb_rational_arithmetic_unit
// self-checking bench for the rational arithmetic unit: a directed set of
// extreme and ordinary operands, then random requests, predicted in 128-bit arithmetic
// with a 64-bit euclid gcd for reduce, checked word by word under random stalls
// ---------------------------------------------------------------------------
module tb_rational_arithmetic_unit;
  import rau_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;

  localparam logic signed [W-1:0] MOST_NEG = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W-1:0] MOST_POS = ~MOST_NEG;

  localparam int N_RANDOM     = 730;
  localparam int QUIET_TAIL   = 120;
  localparam int HOLD_AT      = 200;
  localparam int HOLD_CYCLES  = 4000;
  localparam int DRAIN_CYCLES = 2000;
  localparam int LIMIT_CYCLES = 6000000;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_ready;
  in_word_t  req = '0;
  logic      rsp_valid;
  logic      rsp_ready = 1'b0;
  out_word_t rsp;

  in_word_t  request_q[$];
  out_word_t expected_results[$];

  logic req_taken = 1'b0;
  logic hold_done = 1'b0;
  int   hold_left = 0;
  int   req_gap = 0;
  int   rsp_gap = 0;
  int   req_count = 0;
  int   rsp_count = 0;
  int   plan_total = 1 << 30;
  int   errors = 0;
  int   cycle_count = 0;

  rational_arithmetic_unit uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always #10 clk = ~clk;

  function automatic logic fits_word(logic signed [127:0] v);
    return v == {{(128-W){v[W-1]}}, v[W-1:0]};
  endfunction

  function automatic out_word_t compute_fraction_result(in_word_t w);
    logic signed [127:0] an, ad, bn, bd, vn, vd;
    logic [63:0] n, m, mn, md, g, rem, qn, qd, tn, td;
    logic negn, negd;
    out_word_t r;
    r = '0;
    an = $signed(w.a_num);
    ad = $signed(w.a_den);
    bn = $signed(w.b_num);
    bd = $signed(w.b_den);
    case (w.opcode)
      OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
        vd = ad * bd;
        if (w.opcode == OP_ADD) begin
          vn = an * bd + bn * ad;
        end else if (w.opcode == OP_SUB) begin
          vn = an * bd - bn * ad;
        end else if (w.opcode == OP_MUL) begin
          vn = an * bn;
        end else begin
          vn = an * bd;
          vd = ad * bn;
        end
        r.res_num = vn[W-1:0];
        r.res_den = vd[W-1:0];
        r.status  = (fits_word(vn) && fits_word(vd)) ? ST_OK : ST_OVERFLOW;
      end
      OP_RED: begin
        negn = w.a_num[W-1];
        negd = w.a_den[W-1];
        n = negn ? -an[63:0] : an[63:0];
        m = negd ? -ad[63:0] : ad[63:0];
        mn = n;
        md = m;
        while (n != 0) begin
          rem = m % n;
          m = n;
          n = rem;
        end
        g = m;
        if (g == 0) begin
          r.res_num = w.a_num;
          r.res_den = w.a_den;
          r.status  = ST_ZERO_GCD;
        end else begin
          qn = mn / g;
          qd = md / g;
          tn = negn ? -qn : qn;
          td = negd ? -qd : qd;
          r.res_num = tn[W-1:0];
          r.res_den = td[W-1:0];
          r.status  = ST_OK;
        end
      end
      OP_EQ: begin
        r.is_equal = (w.a_num == w.b_num) && (w.a_den == w.b_den);
      end
      default: begin
        r = '0;
      end
    endcase
    return r;
  endfunction

  function automatic logic signed [W-1:0] pick_operand();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6: return W'(int'($urandom_range(0, 200)) - 100);
      7: begin
        case ($urandom_range(0, 4))
          0: return MOST_NEG;
          1: return MOST_POS;
          2: return '0;
          3: return 1;
          default: return '1;
        endcase
      end
      default: return W'(int'($urandom_range(0, 65535)) - 32768);
    endcase
  endfunction

  task automatic queue_request(logic [2:0] op, logic signed [W-1:0] an,
                               logic signed [W-1:0] ad, logic signed [W-1:0] bn,
                               logic signed [W-1:0] bd);
    in_word_t w;
    w.opcode = op;
    w.a_num  = an;
    w.a_den  = ad;
    w.b_num  = bn;
    w.b_den  = bd;
    request_q.push_back(w);
  endtask

  task automatic queue_random_request();
    logic [2:0] op;
    logic signed [W-1:0] an, ad, bn, bd;
    int f, p, q;
    if ($urandom_range(0, 19) == 0) begin
      op = $urandom_range(0, 1) ? OP_SPARE6 : OP_SPARE7;
    end else begin
      op = 3'($urandom_range(OP_ADD, OP_EQ));
    end
    an = pick_operand();
    ad = pick_operand();
    bn = pick_operand();
    bd = pick_operand();
    if (op == OP_RED && $urandom_range(0, 1)) begin
      // shared factor so the gcd is not trivial
      f = $urandom_range(1, 5000);
      p = int'($urandom_range(0, 80000)) - 40000;
      q = int'($urandom_range(0, 80000)) - 40000;
      an = W'(f * p);
      ad = W'(f * q);
    end
    if (op == OP_EQ) begin
      case ($urandom_range(0, 3))
        0: begin
          bn = an;
          bd = ad;
        end
        1: bn = an;
        2: bd = ad;
        default: ;
      endcase
    end
    queue_request(op, an, ad, bn, bd);
  endtask

  task automatic wait_all_results();
    do @(posedge clk);
    while (request_q.size() != 0 || req_valid || expected_results.size() != 0);
  endtask

  // request driver
  always @(negedge clk) begin : drive_req
    in_word_t nxt_word;
    logic nxt_valid;
    nxt_word  = req;
    nxt_valid = req_valid;
    if (rst) begin
      nxt_valid = 1'b0;
    end else if (!req_valid || req_taken) begin
      nxt_valid = 1'b0;
      if (req_gap > 0) begin
        req_gap--;
      end else if (request_q.size() > 0) begin
        nxt_word  = request_q.pop_front();
        nxt_valid = 1'b1;
        if (req_count < plan_total - QUIET_TAIL && $urandom_range(0, 3) == 0) begin
          req_gap = $urandom_range(1, 3);
        end
      end
    end
    req_valid <= nxt_valid;
    req       <= nxt_word;
  end

  // result receiver
  always @(negedge clk) begin : drive_rsp
    logic rdy;
    rdy = 1'b1;
    if (rst) begin
      rdy = 1'b0;
    end else if (hold_left > 0) begin
      rdy = 1'b0;
    end else if (rsp_gap > 0) begin
      rsp_gap--;
      rdy = 1'b0;
    end else if (req_count < plan_total - QUIET_TAIL && $urandom_range(0, 4) == 0) begin
      rsp_gap = $urandom_range(0, 2);
      rdy = 1'b0;
    end
    rsp_ready <= rdy;
  end

  // one long receiver hold-off so the unit backs up
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && rsp_count == HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_words
    out_word_t exp_w;
    req_taken <= !rst && req_valid && req_ready;
    if (!rst && req_valid && req_ready) begin
      expected_results.push_back(compute_fraction_result(req));
      req_count <= req_count + 1;
    end
    if (!rst && rsp_valid && rsp_ready) begin
      rsp_count <= rsp_count + 1;
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word %h", rsp);
      end else begin
        exp_w = expected_results.pop_front();
        if (rsp.res_num !== exp_w.res_num || rsp.res_den !== exp_w.res_den ||
            rsp.is_equal !== exp_w.is_equal || rsp.status !== exp_w.status) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch: expected %0d/%0d eq=%0d st=%0d, got %0d/%0d eq=%0d st=%0d",
                     exp_w.res_num, exp_w.res_den, exp_w.is_equal, exp_w.status,
                     rsp.res_num, rsp.res_den, rsp.is_equal, rsp.status);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("rational_arithmetic_unit regression: fail");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    queue_request(OP_ADD, MOST_POS, MOST_POS, MOST_POS, MOST_POS);
    queue_request(OP_ADD, 1, 2, 1, 3);
    queue_request(OP_ADD, '1, '1, '1, '1);
    queue_request(OP_SUB, MOST_NEG, 1, 1, MOST_NEG);
    queue_request(OP_SUB, 5, 6, 5, 6);
    queue_request(OP_MUL, MOST_NEG, '1, MOST_NEG, '1);
    queue_request(OP_MUL, 3, 4, -5, 7);
    queue_request(OP_DIV, 1, 2, 0, 3);
    queue_request(OP_DIV, MOST_POS, MOST_NEG, MOST_NEG, MOST_POS);
    queue_request(OP_DIV, -7, 9, 2, -3);
    queue_request(OP_RED, 0, 0, 11, 13);
    queue_request(OP_RED, 0, 5, 0, 0);
    queue_request(OP_RED, 0, -5, 0, 0);
    queue_request(OP_RED, MOST_NEG, 1, 0, 0);
    queue_request(OP_RED, MOST_NEG, MOST_NEG, 0, 0);
    queue_request(OP_RED, 12, -18, MOST_POS, MOST_NEG);
    queue_request(OP_RED, 1836311903, 1134903170, 0, 0);
    queue_request(OP_RED, 7, 0, 0, 0);
    queue_request(OP_RED, MOST_POS, MOST_POS, 0, 0);
    queue_request(OP_EQ, MOST_NEG, MOST_POS, MOST_NEG, MOST_POS);
    queue_request(OP_EQ, 3, 4, 2, 4);
    queue_request(OP_EQ, 3, 4, 3, 5);
    queue_request(OP_SPARE6, MOST_POS, 17, -3, MOST_NEG);
    queue_request(OP_SPARE7, '1, '1, '1, '1);
    plan_total = request_q.size() + N_RANDOM;
    wait_all_results();

    repeat (N_RANDOM / 2) queue_random_request();
    wait_all_results();
    repeat (N_RANDOM - N_RANDOM / 2) queue_random_request();
    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0 && expected_results.size() == 0) begin
      $display("rational_arithmetic_unit regression: pass");
    end else begin
      $display("rational_arithmetic_unit regression: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/rau_pkg.sv
hw/rtl/rau_iter_unit.sv
hw/rtl/rational_arithmetic_unit.sv
verif/tb_rational_arithmetic_unit.sv
